// ===== src/kksf_pkg.sv =====
package kksf_pkg;

	localparam int KEY_COUNT = 128;
	localparam int KEY_W     = $clog2(KEY_COUNT);
	localparam int JOY_COUNT = 12;
	localparam int IDX_W     = $clog2(JOY_COUNT);

	localparam logic [IDX_W-1:0] JOY_LAST = IDX_W'(JOY_COUNT - 1);

	localparam logic [2:0] CMD_KEY   = 3'd0;
	localparam logic [2:0] CMD_FORCE = 3'd1;
	localparam logic [2:0] CMD_JOY   = 3'd2;
	localparam logic [2:0] CMD_COPY  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	localparam logic CFG_LOCK_MASK = 1'b0;
	localparam logic CFG_SUPPRESS  = 1'b1;

	localparam logic [KEY_W-1:0] KEY_SHIFT = 7'h70;
	localparam logic [KEY_W-1:0] KEY_CAPS  = 7'h71;
	localparam logic [KEY_W-1:0] KEY_KANA  = 7'h72;
	localparam logic [KEY_W-1:0] KEY_GRPH  = 7'h73;
	localparam logic [KEY_W-1:0] KEY_CTRL  = 7'h74;
	localparam logic [KEY_W-1:0] KEY_ALT_CAPS = 7'h79;
	localparam logic [KEY_W-1:0] KEY_ALT_KANA = 7'h7a;
	localparam logic [KEY_W-1:0] REMAP_OFS = 7'h08;
	localparam logic [KEY_W-1:0] KEY_COPY  = 7'h60;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_MAKE,
		ST_FLUSH
	} kksf_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic make;
		logic flush;
	} kksf_cmd_t;

	typedef struct packed {
		logic emit_req;
		logic need_make;
		logic last_step;
		logic can_emit;
	} kksf_stat_t;

	// bit0: muted in suppress mode, bit1: no auto-repeat
	function automatic logic [1:0] key_flags(input logic [KEY_W-1:0] k);
		logic [1:0] f;
		f = 2'd0;
		case (k) inside
			7'h1c, 7'h29, 7'h2a, 7'h34, 7'h3a, 7'h3b, 7'h3c, 7'h3d,
			7'h43, 7'h46, 7'h48, 7'h4b: f = 2'd1;
			7'h38, [7'h52:7'h56], [7'h62:7'h6b], [7'h70:7'h74]: f = 2'd2;
			default: f = 2'd0;
		endcase
		return f;
	endfunction

	function automatic logic [KEY_W-1:0] joy_key(input logic [IDX_W-1:0] i);
		logic [KEY_W-1:0] k;
		k = 7'h00;
		unique case (i)
			4'd0:  k = 7'h2a;
			4'd1:  k = 7'h34;
			4'd2:  k = 7'h29;
			4'd3:  k = 7'h1c;
			4'd4:  k = 7'h3c;
			4'd5:  k = 7'h48;
			4'd6:  k = 7'h3b;
			4'd7:  k = 7'h46;
			4'd8:  k = 7'h3d;
			4'd9:  k = 7'h4b;
			4'd10: k = 7'h3a;
			4'd11: k = 7'h43;
			default: k = 7'h00;
		endcase
		return k;
	endfunction

endpackage

// ===== src/kksf_ctrl.sv =====
module kksf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kksf_pkg::kksf_stat_t stat,
	output kksf_pkg::kksf_cmd_t  cmd
);

	kksf_pkg::kksf_state_t state_q, state_d;
	logic go;

	assign go = !stat.emit_req || stat.can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kksf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kksf_pkg::ST_IDLE: begin
				if (in_valid) state_d = kksf_pkg::ST_STEP;
			end
			kksf_pkg::ST_STEP: begin
				if (go) begin
					if (stat.need_make) state_d = kksf_pkg::ST_MAKE;
					else if (stat.last_step) state_d = kksf_pkg::ST_FLUSH;
				end
			end
			kksf_pkg::ST_MAKE: begin
				if (stat.can_emit) state_d = kksf_pkg::ST_FLUSH;
			end
			kksf_pkg::ST_FLUSH: begin
				if (stat.can_emit) state_d = kksf_pkg::ST_IDLE;
			end
			default: state_d = kksf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == kksf_pkg::ST_IDLE);
		cmd.load  = (state_q == kksf_pkg::ST_IDLE) && in_valid;
		cmd.step  = (state_q == kksf_pkg::ST_STEP) && go;
		cmd.make  = (state_q == kksf_pkg::ST_MAKE) && stat.can_emit;
		cmd.flush = (state_q == kksf_pkg::ST_FLUSH) && stat.can_emit;
	end

endmodule

// ===== src/kksf_dp.sv =====
module kksf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [2:0]          cfg_wdata,
	input  logic [2:0]          command,
	input  logic [7:0]          code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          scan_code,
	output logic                last,
	input  kksf_pkg::kksf_cmd_t  cmd,
	output kksf_pkg::kksf_stat_t stat
);

	localparam int KW = kksf_pkg::KEY_W;
	localparam int IW = kksf_pkg::IDX_W;
	localparam int KEY_COUNT_M1 = kksf_pkg::KEY_COUNT - 1;

	logic [2:0]            lock_mask_q;
	logic                  suppress_q;
	logic [KEY_COUNT_M1:0] key_down_q;
	logic [2:0]            cmd_q;
	logic [7:0]            code_q;
	logic [IW-1:0]         idx_q;
	logic                  pend_valid_q;
	logic [7:0]            pend_code_q;
	logic                  out_valid_q;
	logic [7:0]            scan_q;
	logic                  last_q;

	logic [KW-1:0] raw_key, key_evt, sel_key;
	logic          rel, lock, down, repeat_hit, muted;
	logic [1:0]    flags;
	logic          emit_req, need_make, wr_en, wr_val, clear_all, last_step;
	logic [7:0]    emit_code, new_code;
	logic          out_free, can_emit, push, out_load;

	assign raw_key = code_q[KW-1:0];
	assign rel     = code_q[7];
	assign lock    = (raw_key == kksf_pkg::KEY_CAPS) || (raw_key == kksf_pkg::KEY_KANA) ||
		((raw_key == kksf_pkg::KEY_SHIFT) && lock_mask_q[0]) ||
		((raw_key == kksf_pkg::KEY_CTRL) && lock_mask_q[1]) ||
		((raw_key == kksf_pkg::KEY_GRPH) && lock_mask_q[2]);
	assign key_evt = ((raw_key == kksf_pkg::KEY_ALT_CAPS) || (raw_key == kksf_pkg::KEY_ALT_KANA)) ?
		raw_key - kksf_pkg::REMAP_OFS : raw_key;

	always_comb begin
		case (cmd_q)
			kksf_pkg::CMD_KEY:  sel_key = key_evt;
			kksf_pkg::CMD_JOY:  sel_key = kksf_pkg::joy_key(idx_q);
			kksf_pkg::CMD_COPY: sel_key = kksf_pkg::KEY_COPY | {{(KW-1){1'b0}}, idx_q[0]};
			default:            sel_key = raw_key;
		endcase
	end

	assign down       = key_down_q[sel_key];
	assign flags      = kksf_pkg::key_flags(sel_key);
	assign repeat_hit = (down != rel);
	assign muted      = suppress_q && flags[0];

	always_comb begin
		emit_req  = 1'b0;
		emit_code = {1'b1, sel_key};
		need_make = 1'b0;
		wr_en     = 1'b0;
		wr_val    = 1'b0;
		clear_all = 1'b0;
		case (cmd_q) inside
			kksf_pkg::CMD_KEY: begin
				if (lock) begin
					if (!rel) begin
						emit_req  = 1'b1;
						emit_code = {down, sel_key};
						wr_en     = 1'b1;
						wr_val    = !down;
					end
				end else begin
					if (!repeat_hit) begin
						wr_en  = 1'b1;
						wr_val = !rel;
					end
					if (!(repeat_hit && flags[1]) && !muted) begin
						if (repeat_hit) begin
							if (!rel) begin
								emit_req  = 1'b1;
								need_make = 1'b1;
							end
						end else begin
							emit_req  = 1'b1;
							emit_code = {rel, sel_key};
						end
					end
				end
			end
			kksf_pkg::CMD_FORCE, kksf_pkg::CMD_JOY, kksf_pkg::CMD_COPY: begin
				if (down) begin
					emit_req = 1'b1;
					wr_en    = 1'b1;
				end
			end
			kksf_pkg::CMD_CLEAR: clear_all = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (cmd_q)
			kksf_pkg::CMD_JOY:  last_step = (idx_q == kksf_pkg::JOY_LAST);
			kksf_pkg::CMD_COPY: last_step = idx_q[0];
			default:            last_step = 1'b1;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign can_emit = !pend_valid_q || out_free;
	assign push     = (cmd.step && emit_req) || cmd.make;
	assign new_code = cmd.make ? {1'b0, sel_key} : emit_code;
	assign out_load = (push || cmd.flush) && pend_valid_q;

	assign stat.emit_req  = emit_req;
	assign stat.need_make = need_make;
	assign stat.last_step = last_step;
	assign stat.can_emit  = can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_mask_q <= 3'd0;
			suppress_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				kksf_pkg::CFG_LOCK_MASK: lock_mask_q <= cfg_wdata;
				kksf_pkg::CFG_SUPPRESS:  suppress_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q <= '0;
		end else if (cmd.step) begin
			if (clear_all) key_down_q <= '0;
			else if (wr_en) key_down_q[sel_key] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			code_q <= code;
			idx_q  <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
		end
		if (push) pend_code_q <= new_code;
		if (out_load) begin
			scan_q <= pend_code_q;
			last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) pend_valid_q <= 1'b1;
			else if (cmd.flush) pend_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign scan_code = scan_q;
	assign last      = last_q;

endmodule

// ===== src/keyboard_key_state_filter.sv =====
// Throughput: one beat in at a time; each beat passes states idle, step (visiting one
// key per cycle unless the output stalls), make (only for a repeated press) and flush.
// A result waits in the one-entry holding stage until the next result is made or the
// final flush, and then moves into the registered output beat shown on out_valid.
// Reset: all keys released, both config registers zero, no beat pending.
module keyboard_key_state_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [2:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [7:0] code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] scan_code,
	output logic       last
);

	kksf_pkg::kksf_cmd_t  cmd;
	kksf_pkg::kksf_stat_t stat;

	kksf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kksf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.command   (command),
		.code      (code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scan_code (scan_code),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== src/kksf_checker.sv =====
module kksf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_idx,
	input logic [2:0] cfg_wdata,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] command,
	input logic [7:0] code,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] scan_code,
	input logic       last
);

	// output beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scan_code) && $stable(last))
		else $error("output beat changed while stalled");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// when idle, only the final beat of the previous item may remain
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("idle with a non-final beat on the output");

endmodule

bind keyboard_key_state_filter kksf_checker u_kksf_checker (.*);
